@@ sv/kut_pkg.sv @@
// ----------------------------------------------------------------------------
// kut_pkg
// Shared widths, codes and state encoding of the k-mer usage table.
// ----------------------------------------------------------------------------
package kut_pkg;

  localparam int SLOT_W  = 10;
  localparam int ENTRIES = 1 << SLOT_W;

  localparam int KMER_W  = 64;
  localparam int WORD_W  = 64;
  localparam int TPL_W   = 24;
  localparam int LOCUS_W = 16;
  localparam int FREQ_W  = 24;
  localparam int SUM_W   = FREQ_W + 1;
  localparam int KLEN_W  = 6;
  localparam int UPPER_W = WORD_W - FREQ_W;

  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(25);

  typedef enum logic [2:0] {
    ACT_LOAD     = 3'd0,
    ACT_NOP      = 3'd1,
    ACT_MARK     = 3'd2,
    ACT_UNMARK   = 3'd3,
    ACT_IS_USED  = 3'd4,
    ACT_READ     = 3'd5,
    ACT_COUNT    = 3'd6,
    ACT_RF_COUNT = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    USE_NONE  = 2'd0,
    USE_FREE  = 2'd1,
    USE_TAKEN = 2'd2
  } use_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_RD_F,
    ST_UPD_F,
    ST_RD_R,
    ST_UPD_R,
    ST_RESULT
  } state_t;

endpackage

@@ sv/kut_ifs.sv @@
// ----------------------------------------------------------------------------
// kut_ifs
// Request, response and configuration channels of the k-mer usage table.
// ----------------------------------------------------------------------------
interface kut_req_if;
  logic                              valid;
  logic                              ready;
  kut_pkg::action_t                  action;
  logic [kut_pkg::SLOT_W-1:0]        slot;
  logic [kut_pkg::KMER_W-1:0]        kmer;
  logic [kut_pkg::WORD_W-1:0]        entry_word;
  logic [kut_pkg::TPL_W-1:0]         tpl_id;
  logic [kut_pkg::LOCUS_W-1:0]       locus;
  logic [kut_pkg::LOCUS_W-1:0]       template_length;
  logic                              unused_only;

  modport source (output valid, action, slot, kmer, entry_word, tpl_id, locus,
                  template_length, unused_only, input ready);
  modport sink (input valid, action, slot, kmer, entry_word, tpl_id, locus,
                template_length, unused_only, output ready);
endinterface

interface kut_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  kut_pkg::use_t                     use_state;
  logic [kut_pkg::TPL_W-1:0]         template_id_read;
  logic [kut_pkg::LOCUS_W-1:0]       locus_read;
  logic [kut_pkg::SUM_W-1:0]         frequency;

  modport source (output valid, hit, use_state, template_id_read, locus_read,
                  frequency, input ready);
  modport sink (input valid, hit, use_state, template_id_read, locus_read,
                frequency, output ready);
endinterface

interface kut_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kut_pkg::KLEN_W-1:0]        kmer_length;

  modport source (output valid, kmer_length, input ready);
  modport sink (input valid, kmer_length, output ready);
endinterface

@@ sv/kmer_usage_table_core.sv @@
// ----------------------------------------------------------------------------
// kmer_usage_table_core
// Table of k-mer keys with a packed usage word per slot.
// ----------------------------------------------------------------------------
// Channels: req carries one request (load, mark, query), rsp returns exactly
// one result per request, cfg writes the k-mer length and is always ready.
// Write cfg only while no request is in flight.
// Keys and valid flags sit in one key memory, usage words in a word memory,
// each with one registered read port.
// A load or no-op goes from the transfer straight to the result state. Every
// other action scans all 1024 slots through the single key-memory read port,
// matching the forward key and its reverse complement in the same pass, then
// reads the two words and, for a mark or unmark, writes them back. Requests
// are handled one at a time; req.ready is high only between requests.
// After reset a clearing pass walks all 1024 slots of the key memory, one slot
// a cycle, during which no request is taken; cfg writes are taken as usual.
// A finished result waits in the output register while the next request is
// taken; if rsp stalls, the following result holds until the register frees.
// ----------------------------------------------------------------------------
module kmer_usage_table_core (
  input  logic          clk,
  input  logic          rst,
  kut_cfg_if.sink       cfg,
  kut_req_if.sink       req,
  kut_rsp_if.source     rsp
);

  localparam logic [kut_pkg::SLOT_W-1:0] LAST_SLOT = kut_pkg::SLOT_W'(kut_pkg::ENTRIES - 1);
  localparam int FW = kut_pkg::FREQ_W;
  localparam int WW = kut_pkg::WORD_W;
  localparam int LW = kut_pkg::LOCUS_W;

  kut_pkg::state_t                  state;
  kut_pkg::state_t                  state_next;

  logic [kut_pkg::KLEN_W-1:0]       kmer_length;
  logic [kut_pkg::SLOT_W-1:0]       scan_addr;
  logic                             cmp_en;
  logic [kut_pkg::SLOT_W-1:0]       cmp_slot;

  kut_pkg::action_t                 act;
  logic [kut_pkg::KMER_W-1:0]       kmer_q;
  logic [kut_pkg::TPL_W-1:0]        tpl_q;
  logic [LW-1:0]                    loc_q;
  logic [kut_pkg::UPPER_W-1:0]      rev_off;
  logic                             fresh_q;
  logic [kut_pkg::KMER_W-1:0]       rev_key;

  logic                             f_found;
  logic [kut_pkg::SLOT_W-1:0]       f_idx;
  logic                             r_found;
  logic [kut_pkg::SLOT_W-1:0]       r_idx;

  logic [kut_pkg::KMER_W:0]         key_mem [kut_pkg::ENTRIES];
  logic [WW-1:0]                    word_mem [kut_pkg::ENTRIES];
  logic [kut_pkg::KMER_W:0]         key_rdata;
  logic [WW-1:0]                    word_rdata;

  logic                             key_we;
  logic [kut_pkg::SLOT_W-1:0]       key_waddr;
  logic [kut_pkg::KMER_W:0]         key_wdata;
  logic                             word_we;
  logic [kut_pkg::SLOT_W-1:0]       word_waddr;
  logic [WW-1:0]                    word_wdata;
  logic [kut_pkg::SLOT_W-1:0]       word_raddr;

  logic [WW-1:0]                    fwd_word;
  logic [WW-1:0]                    rev_word;
  logic [WW-1:0]                    fwd_new;
  logic [WW-1:0]                    rev_new;
  logic [kut_pkg::UPPER_W-1:0]      fwd_up;
  logic [kut_pkg::UPPER_W-1:0]      rev_up;

  logic                             req_xfer;
  logic                             is_load;
  logic                             is_mark;
  logic                             set_used;
  logic                             out_free;
  logic                             out_load;

  logic                             out_valid;
  logic                             out_hit;
  kut_pkg::use_t                    out_use;
  logic [kut_pkg::TPL_W-1:0]        out_tid;
  logic [LW-1:0]                    out_locus;
  logic [kut_pkg::SUM_W-1:0]        out_freq;

  logic                             used_f;
  logic                             used_r;
  logic [FW-1:0]                    cnt_f;
  logic [FW-1:0]                    cnt_r;
  kut_pkg::use_t                    res_use;
  logic [kut_pkg::SUM_W-1:0]        res_freq;

  assign req_xfer = req.valid && req.ready;
  assign is_load  = (req.action == kut_pkg::ACT_LOAD);
  assign is_mark  = (act == kut_pkg::ACT_MARK) || (act == kut_pkg::ACT_UNMARK);
  assign set_used = (act == kut_pkg::ACT_MARK);
  assign out_free = !out_valid || rsp.ready;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= kut_pkg::KLEN_RESET;
    end else if (cfg.valid) begin
      kmer_length <= cfg.kmer_length;
    end
  end

  kut_revcomp u_revcomp (
    .clk         (clk),
    .load        (req_xfer),
    .kmer        (req.kmer),
    .kmer_length (kmer_length),
    .rev_key     (rev_key)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kut_pkg::ST_CLEAR: begin
        if (scan_addr == LAST_SLOT) state_next = kut_pkg::ST_IDLE;
      end
      kut_pkg::ST_IDLE: begin
        if (req_xfer) begin
          if (is_load || req.action == kut_pkg::ACT_NOP) state_next = kut_pkg::ST_RESULT;
          else state_next = kut_pkg::ST_SCAN;
        end
      end
      kut_pkg::ST_SCAN: begin
        if (scan_addr == LAST_SLOT) state_next = kut_pkg::ST_TAIL;
      end
      kut_pkg::ST_TAIL:   state_next = kut_pkg::ST_RD_F;
      kut_pkg::ST_RD_F:   state_next = kut_pkg::ST_UPD_F;
      kut_pkg::ST_UPD_F:  state_next = kut_pkg::ST_RD_R;
      kut_pkg::ST_RD_R:   state_next = kut_pkg::ST_UPD_R;
      kut_pkg::ST_UPD_R:  state_next = kut_pkg::ST_RESULT;
      kut_pkg::ST_RESULT: begin
        if (out_free) state_next = kut_pkg::ST_IDLE;
      end
      default: state_next = kut_pkg::ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready  = 1'b0;
    key_we     = 1'b0;
    key_waddr  = req.slot;
    key_wdata  = {1'b1, req.kmer};
    word_we    = 1'b0;
    word_waddr = req.slot;
    word_wdata = req.entry_word;
    word_raddr = r_idx;
    out_load   = 1'b0;
    unique case (state)
      kut_pkg::ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = scan_addr;
        key_wdata = '0;
      end
      kut_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        key_we    = req.valid && is_load;
        word_we   = req.valid && is_load;
      end
      kut_pkg::ST_RD_F: begin
        word_raddr = f_idx;
      end
      kut_pkg::ST_UPD_F: begin
        word_we    = is_mark && f_found;
        word_waddr = f_idx;
        word_wdata = fwd_new;
      end
      kut_pkg::ST_UPD_R: begin
        word_we    = is_mark && r_found;
        word_waddr = r_idx;
        word_wdata = rev_new;
      end
      kut_pkg::ST_RESULT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kut_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata <= key_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_waddr] <= word_wdata;
    end
    word_rdata <= word_mem[word_raddr];
  end

  // scan counter, also walks the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      cmp_en    <= 1'b0;
    end else begin
      cmp_en <= (state == kut_pkg::ST_SCAN);
      if (state == kut_pkg::ST_CLEAR || state == kut_pkg::ST_SCAN) begin
        scan_addr <= scan_addr + 1'b1;
      end else begin
        scan_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_slot <= scan_addr;
  end

  // request hold
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      act     <= req.action;
      kmer_q  <= req.kmer;
      tpl_q   <= req.tpl_id;
      loc_q   <= req.locus;
      fresh_q <= req.unused_only;
      rev_off <= kut_pkg::UPPER_W'(req.template_length) - kut_pkg::UPPER_W'(req.locus)
                 - kut_pkg::UPPER_W'(kmer_length);
    end
  end

  // first valid match for forward and reverse keys
  always_ff @(posedge clk) begin
    if (rst) begin
      f_found <= 1'b0;
      r_found <= 1'b0;
    end else if (req_xfer) begin
      f_found <= 1'b0;
      r_found <= 1'b0;
    end else if (cmp_en) begin
      if (!f_found && key_rdata[kut_pkg::KMER_W] &&
          key_rdata[kut_pkg::KMER_W-1:0] == kmer_q) begin
        f_found <= 1'b1;
      end
      if (!r_found && key_rdata[kut_pkg::KMER_W] &&
          key_rdata[kut_pkg::KMER_W-1:0] == rev_key) begin
        r_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      if (!f_found) f_idx <= cmp_slot;
      if (!r_found) r_idx <= cmp_slot;
    end
  end

  // read, modify, write back
  assign fwd_up  = set_used ? {tpl_q, loc_q} : '0;
  assign rev_up  = set_used ? ({tpl_q, {LW{1'b0}}} + rev_off) : '0;
  assign fwd_new = {fwd_up, word_rdata[FW-1:0]};
  assign rev_new = {rev_up, word_rdata[FW-1:0]};

  always_ff @(posedge clk) begin
    if (state == kut_pkg::ST_UPD_F) begin
      fwd_word <= is_mark ? fwd_new : word_rdata;
    end else if (state == kut_pkg::ST_UPD_R) begin
      rev_word <= is_mark ? rev_new : word_rdata;
      // reverse write wins on a self-complementary key
      if (f_found && r_found && f_idx == r_idx) begin
        fwd_word <= is_mark ? rev_new : word_rdata;
      end
    end
  end

  // result
  assign used_f = |fwd_word[WW-1:FW];
  assign used_r = |rev_word[WW-1:FW];
  assign cnt_f  = (fresh_q && used_f) ? '0 : fwd_word[FW-1:0];
  assign cnt_r  = (!r_found || (fresh_q && used_r)) ? '0 : rev_word[FW-1:0];

  always_comb begin
    res_use  = kut_pkg::USE_NONE;
    res_freq = '0;
    if (f_found) begin
      res_use = used_f ? kut_pkg::USE_TAKEN : kut_pkg::USE_FREE;
      case (act)
        kut_pkg::ACT_COUNT:    res_freq = {1'b0, cnt_f};
        kut_pkg::ACT_RF_COUNT: res_freq = {1'b0, cnt_f} + {1'b0, cnt_r};
        default:               res_freq = {1'b0, fwd_word[FW-1:0]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit   <= f_found;
      out_use   <= res_use;
      out_tid   <= f_found ? fwd_word[WW-1:WW-kut_pkg::TPL_W] : '0;
      out_locus <= f_found ? fwd_word[FW+LW-1:FW] : '0;
      out_freq  <= res_freq;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.hit              = out_hit;
  assign rsp.use_state        = out_use;
  assign rsp.template_id_read = out_tid;
  assign rsp.locus_read       = out_locus;
  assign rsp.frequency        = out_freq;

  // checks
  a_hit_use : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.hit) |->
      (rsp.use_state == kut_pkg::USE_FREE || rsp.use_state == kut_pkg::USE_TAKEN))
    else $error("hit result without a used/unused state");

  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.hit) |->
      (rsp.use_state == kut_pkg::USE_NONE && rsp.frequency == '0 &&
       rsp.template_id_read == '0 && rsp.locus_read == '0))
    else $error("miss result carries nonzero fields");

  a_first_match : assert property (@(posedge clk) disable iff (rst)
    (state == kut_pkg::ST_SCAN && f_found) |=> (f_found && $stable(f_idx)))
    else $error("forward match moved during scan");

  a_rev_write : assert property (@(posedge clk) disable iff (rst)
    (word_we && state == kut_pkg::ST_UPD_R) |-> r_found)
    else $error("reverse word written without a match");

  a_no_req_clear : assert property (@(posedge clk) disable iff (rst)
    (state == kut_pkg::ST_CLEAR) |-> !req_xfer)
    else $error("request transfer during clearing pass");

endmodule

@@ sv/kut_revcomp.sv @@
// ----------------------------------------------------------------------------
// kut_revcomp
// Registered reverse complement of a k-mer over a configurable base count.
// ----------------------------------------------------------------------------
module kut_revcomp (
  input  logic                         clk,
  input  logic                         load,
  input  logic [kut_pkg::KMER_W-1:0]   kmer,
  input  logic [kut_pkg::KLEN_W-1:0]   kmer_length,
  output logic [kut_pkg::KMER_W-1:0]   rev_key
);

  localparam int BASES = kut_pkg::KMER_W / 2;

  logic [kut_pkg::KMER_W-1:0]     cpl_rev;
  logic [3*kut_pkg::KMER_W-1:0]   wide;
  logic [3*kut_pkg::KMER_W-1:0]   shifted;
  logic [7:0]                     shamt;

  always_comb begin
    for (int b = 0; b < BASES; b++) begin
      cpl_rev[2*b +: 2] = ~kmer[2*(BASES-1-b) +: 2];
    end
  end

  // bases past the key read as zero, so their complement is all ones
  assign wide    = {{kut_pkg::KMER_W{1'b0}}, cpl_rev, {kut_pkg::KMER_W{1'b1}}};
  assign shamt   = 8'(2 * kut_pkg::KMER_W) - {1'b0, kmer_length, 1'b0};
  assign shifted = wide >> shamt;

  always_ff @(posedge clk) begin
    if (load) begin
      rev_key <= shifted[kut_pkg::KMER_W-1:0];
    end
  end

endmodule

@@ sim/kmer_usage_table_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmer_usage_table_core_tb
// Self-checking bench for the k-mer usage table core.
// A class mirrors the key table, the usage words and the k-mer length, and
// predicts one result for every request transfer. Each response transfer is
// checked field by field against the oldest prediction. A directed section
// covers table extremes, every action, borrowing reverse loci, duplicate keys
// and palindromic k-mers. Randomized phases follow under several k-mer
// lengths and idle/stall profiles on both sides.
// ----------------------------------------------------------------------------
module kmer_usage_table_core_tb;

  typedef struct {
    kut_pkg::action_t                  action;
    logic [kut_pkg::SLOT_W-1:0]        slot;
    logic [kut_pkg::KMER_W-1:0]        kmer;
    logic [kut_pkg::WORD_W-1:0]        entry_word;
    logic [kut_pkg::TPL_W-1:0]         tpl_id;
    logic [kut_pkg::LOCUS_W-1:0]       locus;
    logic [kut_pkg::LOCUS_W-1:0]       template_length;
    logic                              unused_only;
  } kmer_request_t;

  typedef struct {
    logic                              hit;
    kut_pkg::use_t                     use_state;
    logic [kut_pkg::TPL_W-1:0]         template_id_read;
    logic [kut_pkg::LOCUS_W-1:0]       locus_read;
    logic [kut_pkg::SUM_W-1:0]         frequency;
  } kmer_result_t;

  class kmer_usage_mirror;
    logic [kut_pkg::KMER_W-1:0] keys [kut_pkg::ENTRIES];
    logic [kut_pkg::WORD_W-1:0] words [kut_pkg::ENTRIES];
    bit                         filled [kut_pkg::ENTRIES];
    logic [kut_pkg::KLEN_W-1:0] klen = kut_pkg::KLEN_RESET;
    kmer_result_t               awaited[$];
    int                         errors;
    int                         requests;
    int                         results;
    int                         hits;

    function logic [63:0] rc_key(logic [63:0] key, int len);
      logic [63:0] k;
      logic [63:0] rc;
      k = key;
      rc = '0;
      for (int n = 0; n < len; n++) begin
        rc = {rc[61:0], ~k[1:0]};
        k = k >> 2;
      end
      return rc;
    endfunction

    function int find_entry(logic [63:0] key);
      for (int i = 0; i < kut_pkg::ENTRIES; i++) begin
        if (filled[i] && keys[i] == key) return i;
      end
      return -1;
    endfunction

    function logic [kut_pkg::SUM_W-1:0] entry_count(logic [63:0] key, bit fresh);
      int s;
      s = find_entry(key);
      if (s < 0) return '0;
      if (fresh && words[s][63:24] != '0) return '0;
      return {1'b0, words[s][23:0]};
    endfunction

    function void note_request(kmer_request_t r);
      kmer_result_t want;
      logic [63:0]  rev;
      logic [63:0]  w;
      logic [63:0]  rsum;
      int           f;
      int           rs;
      want.hit = 1'b0;
      want.use_state = kut_pkg::USE_NONE;
      want.template_id_read = '0;
      want.locus_read = '0;
      want.frequency = '0;
      requests++;
      rev = rc_key(r.kmer, klen);
      if (r.action == kut_pkg::ACT_LOAD) begin
        keys[r.slot] = r.kmer;
        words[r.slot] = r.entry_word;
        filled[r.slot] = 1'b1;
      end else if (r.action == kut_pkg::ACT_MARK || r.action == kut_pkg::ACT_UNMARK) begin
        f = find_entry(r.kmer);
        if (f >= 0) begin
          w = {40'd0, words[f][23:0]};
          if (r.action == kut_pkg::ACT_MARK) w[63:24] = {r.tpl_id, r.locus};
          words[f] = w;
        end
        rs = find_entry(rev);
        if (rs >= 0) begin
          w = {40'd0, words[rs][23:0]};
          if (r.action == kut_pkg::ACT_MARK) begin
            rsum = ({40'd0, r.tpl_id} << 16) + {48'd0, r.template_length}
                   - {48'd0, r.locus} - {58'd0, klen};
            w[63:24] = rsum[39:0];
          end
          words[rs] = w;
        end
      end
      if (r.action != kut_pkg::ACT_LOAD && r.action != kut_pkg::ACT_NOP) begin
        f = find_entry(r.kmer);
        if (f >= 0) begin
          w = words[f];
          want.hit = 1'b1;
          want.use_state = (w[63:24] != '0) ? kut_pkg::USE_TAKEN : kut_pkg::USE_FREE;
          want.template_id_read = w[63:40];
          want.locus_read = w[39:24];
          if (r.action == kut_pkg::ACT_COUNT)
            want.frequency = entry_count(r.kmer, r.unused_only);
          else if (r.action == kut_pkg::ACT_RF_COUNT)
            want.frequency = entry_count(r.kmer, r.unused_only) +
                             entry_count(rev, r.unused_only);
          else
            want.frequency = {1'b0, w[23:0]};
        end
      end
      awaited.push_back(want);
    endfunction

    function void check_result(kmer_result_t got);
      kmer_result_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      want = awaited.pop_front();
      results++;
      if (want.hit) hits++;
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.use_state !== want.use_state) begin
        $error("use_state: expected %0d, got %0d", want.use_state, got.use_state);
        errors++;
      end
      if (got.template_id_read !== want.template_id_read) begin
        $error("template_id_read: expected 0x%0h, got 0x%0h", want.template_id_read,
               got.template_id_read);
        errors++;
      end
      if (got.locus_read !== want.locus_read) begin
        $error("locus_read: expected 0x%0h, got 0x%0h", want.locus_read, got.locus_read);
        errors++;
      end
      if (got.frequency !== want.frequency) begin
        $error("frequency: expected 0x%0h, got 0x%0h", want.frequency, got.frequency);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  kut_cfg_if cfg_ch ();
  kut_req_if req_ch ();
  kut_rsp_if rsp_ch ();

  kmer_usage_table_core dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  kmer_usage_mirror mirror = new;
  logic [63:0]      loaded_keys[$];
  int               send_idle_pct;
  int               rcv_stall_pct;
  int               settings_used;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic kmer_request_t make_request(kut_pkg::action_t act, logic [63:0] key);
    kmer_request_t it;
    it.action = act;
    it.slot = $urandom_range(1) ? kut_pkg::SLOT_W'($urandom_range(15))
                                : kut_pkg::SLOT_W'($urandom);
    it.kmer = key;
    it.entry_word = rand64();
    it.tpl_id = kut_pkg::TPL_W'($urandom);
    it.locus = kut_pkg::LOCUS_W'($urandom);
    it.template_length = kut_pkg::LOCUS_W'($urandom);
    it.unused_only = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic logic [63:0] pick_key();
    int unsigned r;
    int          half;
    logic [63:0] k;
    logic [63:0] a;
    r = $urandom_range(99);
    k = rand64();
    if (r < 45) begin
      if (mirror.klen > 0 && mirror.klen < 32) k &= (64'd1 << (2 * mirror.klen)) - 1;
    end else if (r < 60) begin
      k = rand64();
    end else if (r < 72 && mirror.klen >= 2 && mirror.klen <= 32 && !mirror.klen[0]) begin
      half = mirror.klen / 2;
      a = k & ((64'd1 << (2 * half)) - 1);
      k = (a << (2 * half)) | mirror.rc_key(a, half);
    end else if (r < 80) begin
      k = $urandom_range(1) ? '0 : '1;
    end else if (loaded_keys.size() > 0) begin
      k = mirror.rc_key(loaded_keys[$urandom_range(loaded_keys.size() - 1)], mirror.klen);
    end
    return k;
  endfunction

  function automatic kmer_request_t random_request();
    kmer_request_t it;
    int unsigned   r;
    logic [63:0]   k;
    r = $urandom_range(99);
    if (r < 30) begin
      if ($urandom_range(3) == 0 && loaded_keys.size() > 0)
        k = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
      else
        k = pick_key();
      it = make_request(kut_pkg::ACT_LOAD, k);
      if ($urandom_range(1)) it.entry_word[63:24] = '0;
      loaded_keys.push_back(k);
      if (loaded_keys.size() > 48) void'(loaded_keys.pop_front());
    end else if (r < 34) begin
      it = make_request(kut_pkg::ACT_NOP, rand64());
    end else begin
      if ($urandom_range(9) < 7 && loaded_keys.size() > 0)
        k = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
      else
        k = pick_key();
      it = make_request(kut_pkg::action_t'($urandom_range(kut_pkg::ACT_MARK,
                                                          kut_pkg::ACT_RF_COUNT)), k);
    end
    return it;
  endfunction

  task automatic send_request(input kmer_request_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= it.action;
    req_ch.slot <= it.slot;
    req_ch.kmer <= it.kmer;
    req_ch.entry_word <= it.entry_word;
    req_ch.tpl_id <= it.tpl_id;
    req_ch.locus <= it.locus;
    req_ch.template_length <= it.template_length;
    req_ch.unused_only <= it.unused_only;
    do @(posedge clk); while (!req_ch.ready);
    mirror.note_request(it);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_kmer_length(input logic [kut_pkg::KLEN_W-1:0] len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.kmer_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    mirror.klen = len;
    settings_used++;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        rcv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 52;
        rcv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        rcv_stall_pct = 52;
      end
      default: begin
        send_idle_pct = 36;
        rcv_stall_pct = 36;
      end
    endcase
  endtask

  initial begin
    kmer_result_t got;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.hit = rsp_ch.hit;
        got.use_state = rsp_ch.use_state;
        got.template_id_read = rsp_ch.template_id_read;
        got.locus_read = rsp_ch.locus_read;
        got.frequency = rsp_ch.frequency;
        mirror.check_result(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  initial begin
    kmer_request_t it;
    logic [63:0]   k1;
    logic [63:0]   rc1;
    int            phase_len[8];

    set_idling(0);
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.kmer_length <= kut_pkg::KLEN_RESET;
    req_ch.valid <= 1'b0;
    req_ch.action <= kut_pkg::ACT_NOP;
    req_ch.slot <= '0;
    req_ch.kmer <= '0;
    req_ch.entry_word <= '0;
    req_ch.tpl_id <= '0;
    req_ch.locus <= '0;
    req_ch.template_length <= '0;
    req_ch.unused_only <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed section, reset k-mer length
    k1 = rand64() & ((64'd1 << 50) - 1);
    rc1 = mirror.rc_key(k1, kut_pkg::KLEN_RESET);
    send_request(make_request(kut_pkg::ACT_IS_USED, 64'd0));
    it = make_request(kut_pkg::ACT_LOAD, k1);
    it.slot = '0;
    it.entry_word = {40'd0, 24'hFFFFFF};
    send_request(it);
    it = make_request(kut_pkg::ACT_LOAD, rc1);
    it.slot = '1;
    it.entry_word = '1;
    send_request(it);
    it = make_request(kut_pkg::ACT_NOP, '1);
    it.slot = '1;
    it.entry_word = '1;
    it.tpl_id = '1;
    it.locus = '1;
    it.template_length = '1;
    it.unused_only = 1'b1;
    send_request(it);
    send_request(make_request(kut_pkg::ACT_READ, k1));
    it = make_request(kut_pkg::ACT_COUNT, k1);
    it.unused_only = 1'b0;
    send_request(it);
    it = make_request(kut_pkg::ACT_COUNT, rc1);
    it.unused_only = 1'b1;
    send_request(it);
    it = make_request(kut_pkg::ACT_RF_COUNT, k1);
    it.unused_only = 1'b0;
    send_request(it);
    it.unused_only = 1'b1;
    send_request(it);
    it = make_request(kut_pkg::ACT_MARK, k1);
    it.tpl_id = '1;
    it.locus = '0;
    it.template_length = '0;
    send_request(it);
    send_request(make_request(kut_pkg::ACT_IS_USED, rc1));
    it = make_request(kut_pkg::ACT_MARK, k1);
    it.tpl_id = '0;
    it.locus = '1;
    it.template_length = '1;
    send_request(it);
    send_request(make_request(kut_pkg::ACT_UNMARK, rc1));
    it = make_request(kut_pkg::ACT_RF_COUNT, k1);
    it.unused_only = 1'b1;
    send_request(it);
    it = make_request(kut_pkg::ACT_LOAD, k1);
    it.slot = 10'd7;
    send_request(it);
    send_request(make_request(kut_pkg::ACT_READ, k1));
    it = make_request(kut_pkg::ACT_LOAD, '1);
    it.slot = 10'd5;
    it.entry_word = '0;
    send_request(it);
    it = make_request(kut_pkg::ACT_LOAD, '0);
    it.slot = 10'd6;
    send_request(it);
    send_request(make_request(kut_pkg::ACT_MARK, '1));
    send_request(make_request(kut_pkg::ACT_IS_USED, '0));
    loaded_keys.push_back(k1);
    loaded_keys.push_back(rc1);

    // palindromic k-mer under an even length
    drain_results();
    write_kmer_length(kut_pkg::KLEN_W'(2));
    it = make_request(kut_pkg::ACT_LOAD, 64'd3);
    it.slot = 10'd8;
    send_request(it);
    send_request(make_request(kut_pkg::ACT_MARK, 64'd3));
    it = make_request(kut_pkg::ACT_RF_COUNT, 64'd3);
    it.unused_only = 1'b0;
    send_request(it);

    phase_len = '{1, 32, 0, 63, 25, 1, 1, 16};
    phase_len[5] = $urandom_range(1, 32);
    phase_len[6] = $urandom_range(1, 32);
    for (int p = 0; p < 8; p++) begin
      drain_results();
      write_kmer_length(kut_pkg::KLEN_W'(phase_len[p]));
      set_idling(p % 4);
      repeat (34) send_request(random_request());
    end

    drain_results();
    repeat (2100) @(posedge clk);
    $display("Sent %0d requests under %0d k-mer length settings", mirror.requests,
             settings_used);
    $display("Checked %0d results, %0d of them table hits", mirror.results, mirror.hits);
    if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
